>>> rtl/core/dett_pkg.sv
// Package for the delayed event timer table: request, result and slot entry types,
// function and status codes, and helpers that build result items.
// Depends on nothing; every other file of the block imports it.
`timescale 1ns / 1ps
`default_nettype none

package dett_pkg;

  // Function codes of a request.
  localparam logic [1:0] FUNC_REGISTER = 2'd0;
  localparam logic [1:0] FUNC_TICK     = 2'd1;
  localparam logic [1:0] FUNC_REMOVE   = 2'd2;

  // Status codes of a result.
  localparam logic [2:0] ST_REGISTERED = 3'd0;
  localparam logic [2:0] ST_FULL       = 3'd1;
  localparam logic [2:0] ST_EXPIRED    = 3'd2;
  localparam logic [2:0] ST_NONE       = 3'd3;
  localparam logic [2:0] ST_REMOVED    = 3'd4;

  // Width of the removal count on the result.
  localparam int COUNT_W = 7;

  // One request item.
  typedef struct packed {
    logic [1:0]         func;
    logic [3:0]         event_kind;
    logic [15:0]        effect;
    logic [7:0]         map_index;
    logic [15:0]        pos_x;
    logic [15:0]        pos_y;
    logic [15:0]        target_id;
    logic signed [31:0] value_one;
    logic signed [31:0] value_two;
    logic signed [31:0] value_three;
    logic [31:0]        time_value;
  } request_t;

  // One result item.
  typedef struct packed {
    logic [2:0]         status;
    logic [3:0]         out_kind;
    logic [15:0]        out_effect;
    logic [7:0]         out_map;
    logic [15:0]        out_x;
    logic [15:0]        out_y;
    logic [15:0]        out_target;
    logic signed [31:0] out_one;
    logic signed [31:0] out_two;
    logic signed [31:0] out_three;
    logic [COUNT_W-1:0] removed_count;
    logic               last;
  } result_t;

  // One stored timer slot.
  typedef struct packed {
    logic [3:0]  kind;
    logic [15:0] effect;
    logic [7:0]  map_index;
    logic [15:0] pos_x;
    logic [15:0] pos_y;
    logic [15:0] target;
    logic [31:0] arg_one;
    logic [31:0] arg_two;
    logic [31:0] arg_three;
    logic [31:0] trigger;
  } entry_t;

  // Builds the slot entry that a register request stores.
  function automatic entry_t entry_from_request(request_t req);
    entry_t e;
    e.kind      = req.event_kind;
    e.effect    = req.effect;
    e.map_index = req.map_index;
    e.pos_x     = req.pos_x;
    e.pos_y     = req.pos_y;
    e.target    = req.target_id;
    e.arg_one   = req.value_one;
    e.arg_two   = req.value_two;
    e.arg_three = req.value_three;
    e.trigger   = req.time_value;
    return e;
  endfunction

  // A result that carries only a status and the last flag; all other fields are zero.
  function automatic result_t status_result(logic [2:0] st, logic fin);
    result_t r;
    r        = '0;
    r.status = st;
    r.last   = fin;
    return r;
  endfunction

  // A result that reports an expired slot.
  function automatic result_t expired_result(entry_t e);
    result_t r;
    r            = '0;
    r.status     = ST_EXPIRED;
    r.out_kind   = e.kind;
    r.out_effect = e.effect;
    r.out_map    = e.map_index;
    r.out_x      = e.pos_x;
    r.out_y      = e.pos_y;
    r.out_target = e.target;
    r.out_one    = e.arg_one;
    r.out_two    = e.arg_two;
    r.out_three  = e.arg_three;
    return r;
  endfunction

endpackage

`default_nettype wire

>>> rtl/core/dett_slot_ram.sv
// Slot memory of the delayed event timer table: one write port and one read
// port with registered read data. Depends on dett_pkg for the entry type.
`timescale 1ns / 1ps
`default_nettype none

module dett_slot_ram
  import dett_pkg::*;
#(
  parameter int DEPTH = 64,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic              clk,
  input  wire logic              wr_en,
  input  wire logic [ADDR_W-1:0] wr_addr,
  input  wire entry_t            wr_data,
  input  wire logic              rd_en,
  input  wire logic [ADDR_W-1:0] rd_addr,
  output entry_t                 rd_data
);

  entry_t mem [DEPTH];

  // Write and registered read, one of each per cycle.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/delayed_event_timer_table_unit.sv
// Top level of the delayed event timer table: command sequencer, slot valid
// bits and result register. Depends on dett_pkg and dett_slot_ram.
//
//   Channel   Ports                   Transfer when
//   --------  ----------------------  ---------------------------------------
//   request   start, busy, request    rising edge with start high, busy low
//   result    result_strobe, result   every cycle with result_strobe high
//
// A register request walks the valid bits one slot per cycle until it finds a
// free one or reaches the last slot. Tick and remove read the slot memory one
// entry per cycle, compare each entry in the cycle after its read and finish
// with a flush state. Busy stays high for the whole command.
// Reset clears the valid bits at once; slot contents need no clearing.
// Results come out at most one per cycle and cannot be held off.
`timescale 1ns / 1ps
`default_nettype none

module delayed_event_timer_table_unit
  import dett_pkg::*;
#(
  parameter int TABLE_DEPTH = 64
) (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     start,
  output logic          busy,
  input  wire request_t request,
  output logic          result_strobe,
  output result_t       result
);

  localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_DEPTH - 1);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_FIND  = 4'b0010,
    S_SCAN  = 4'b0100,
    S_FLUSH = 4'b1000
  } state_t;

  state_t            state;
  request_t          cmd;
  logic [IDX_W-1:0]  idx;
  logic              issue_done;
  logic              s1_vld;
  logic [IDX_W-1:0]  s1_idx;
  logic              s1_last;
  logic [TABLE_DEPTH-1:0] slot_valid;
  result_t           pend;
  logic              pend_vld;
  logic [CNT_W-1:0]  rem_cnt;

  logic    accept;
  logic    wr_en;
  logic    rd_en;
  entry_t  rd_entry;
  logic    slot_hit;
  result_t flush_res;

  assign busy   = (state != S_IDLE);
  assign accept = start && !busy;

  // A register request writes the first free slot it finds.
  assign wr_en = (state == S_FIND) && !slot_valid[idx];
  // Tick and remove read every slot once.
  assign rd_en = (state == S_SCAN) && !issue_done;

  dett_slot_ram #(
    .DEPTH (TABLE_DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (idx),
    .wr_data (entry_from_request(cmd)),
    .rd_en   (rd_en),
    .rd_addr (idx),
    .rd_data (rd_entry)
  );

  // Compare stage: the slot read last cycle either expired or matches the removal.
  always_comb begin
    slot_hit = 1'b0;
    if (s1_vld && slot_valid[s1_idx]) begin
      if (cmd.func == FUNC_TICK) begin
        slot_hit = (rd_entry.trigger < cmd.time_value);
      end else begin
        slot_hit = (rd_entry.target == cmd.target_id) &&
                   ((cmd.effect == 16'd0) || (rd_entry.effect == cmd.effect));
      end
    end
  end

  // Final result of a scan: the held expired entry, a none result or the removal count.
  always_comb begin
    flush_res      = pend;
    flush_res.last = 1'b1;
    if (cmd.func == FUNC_TICK) begin
      if (!pend_vld) begin
        flush_res = status_result(ST_NONE, 1'b1);
      end
    end else begin
      flush_res               = status_result(ST_REMOVED, 1'b1);
      flush_res.removed_count = COUNT_W'(rem_cnt);
    end
  end

  // Sequencer and control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      slot_valid    <= '0;
      result_strobe <= 1'b0;
      pend_vld      <= 1'b0;
      s1_vld        <= 1'b0;
      issue_done    <= 1'b0;
      idx           <= '0;
      rem_cnt       <= '0;
    end else begin
      result_strobe <= 1'b0;
      s1_vld        <= rd_en;
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            idx        <= '0;
            issue_done <= 1'b0;
            pend_vld   <= 1'b0;
            rem_cnt    <= '0;
            case (request.func) inside
              FUNC_REGISTER:          state <= S_FIND;
              FUNC_TICK, FUNC_REMOVE: state <= S_SCAN;
              default:                state <= S_IDLE;
            endcase
          end
        end
        S_FIND: begin
          if (!slot_valid[idx]) begin
            slot_valid[idx] <= 1'b1;
            result_strobe   <= 1'b1;
            state           <= S_IDLE;
          end else if (idx == LAST_IDX) begin
            result_strobe <= 1'b1;
            state         <= S_IDLE;
          end else begin
            idx <= idx + IDX_W'(1);
          end
        end
        S_SCAN: begin
          if (rd_en) begin
            if (idx == LAST_IDX) begin
              issue_done <= 1'b1;
            end else begin
              idx <= idx + IDX_W'(1);
            end
          end
          if (slot_hit) begin
            slot_valid[s1_idx] <= 1'b0;
            if (cmd.func == FUNC_TICK) begin
              // The previous hit goes out now; this one waits to learn if it is last.
              pend_vld <= 1'b1;
              if (pend_vld) begin
                result_strobe <= 1'b1;
              end
            end else begin
              rem_cnt <= rem_cnt + CNT_W'(1);
            end
          end
          if (s1_vld && s1_last) begin
            state <= S_FLUSH;
          end
        end
        S_FLUSH: begin
          result_strobe <= 1'b1;
          state         <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Command, pipeline and result payload.
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd <= request;
    end
    s1_idx  <= idx;
    s1_last <= (idx == LAST_IDX);
    if (state == S_FIND) begin
      result <= status_result(slot_valid[idx] ? ST_FULL : ST_REGISTERED, 1'b1);
    end
    if ((state == S_SCAN) && slot_hit && (cmd.func == FUNC_TICK)) begin
      pend   <= expired_result(rd_entry);
      result <= pend;
    end
    if (state == S_FLUSH) begin
      result <= flush_res;
    end
  end

endmodule

`default_nettype wire
